// ===== design/ecbt_pkg.sv =====
// Shared types, codes and constants of the edge coverage bitmap tracker.
package ecbt_pkg;

  localparam int MAP_AW      = 16;
  localparam int MAP_BYTES   = 1 << MAP_AW;
  localparam int LOC_W       = MAP_AW - 1;
  localparam int LIMIT_W     = MAP_AW + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_BLOCK_END = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  localparam logic [2:0] REG_TRACING_ENABLE     = 3'd0;
  localparam logic [2:0] REG_CODE_START         = 3'd1;
  localparam logic [2:0] REG_CODE_END           = 3'd2;
  localparam logic [2:0] REG_INSTRUMENT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_HANG_LIMIT         = 3'd4;
  localparam logic [2:0] REG_CRASH_POINT_ADDR   = 3'd5;
  localparam logic [2:0] REG_CRASH_POINT_ENABLE = 3'd6;

  localparam logic [8:0] SYSTICK_EXC     = 9'd15;
  localparam logic [8:0] FAULT_EXC_LIMIT = 9'd10;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_INC,
    CMD_MARK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [MAP_AW-1:0] addr;
    logic              crash;
    logic              hang;
    logic              fault;
  } cmd_t;

  typedef struct packed {
    logic               tracing_enable;
    logic [31:0]        code_start;
    logic [31:0]        code_end;
    logic [LIMIT_W-1:0] instrument_limit;
    logic [31:0]        hang_limit;
    logic [31:0]        crash_point_addr;
    logic               crash_point_enable;
  } cfg_t;

endpackage

// ===== design/ecbt_front.sv =====
// Front end: accepts items, classifies them and keeps the edge and tick state.
module ecbt_front import ecbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        clearing,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] block_addr,
  input  logic        irq_active,
  input  logic [8:0]  exception_number,
  input  logic [15:0] read_index,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [LOC_W-1:0]  hist_loc, hist_loc_next;
  logic [31:0]       tick_count, tick_count_next;
  logic [MAP_AW-1:0] hash;
  logic [LOC_W-1:0]  edge_loc;
  logic [MAP_AW-1:0] mark_idx;
  logic              in_window;
  logic              exc_ignored;
  logic              is_systick;

  // Low bits of (a >> 8) ^ (a << 4); only the low LOC_W bits of it are ever used.
  assign hash        = block_addr[23:8] ^ {block_addr[11:0], 4'h0};
  assign edge_loc    = hash[LOC_W-1:0];
  assign mark_idx    = {1'b1, hash[LOC_W-1:0]};
  assign in_window   = (block_addr >= cfg.code_start) && (block_addr <= cfg.code_end);
  assign exc_ignored = irq_active && (exception_number > SYSTICK_EXC);
  assign is_systick  = irq_active && (exception_number == SYSTICK_EXC);

  assign in_ready = q_ready && !clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_cmd           = '0;
    q_cmd.kind      = CMD_NONE;
    hist_loc_next   = hist_loc;
    tick_count_next = tick_count;
    unique case (op)
      OP_TICK: begin
        if (tick_count != '1) begin
          tick_count_next = tick_count + 32'd1;
        end
      end
      OP_READ: begin
        q_cmd.kind = CMD_READ;
        q_cmd.addr = read_index;
      end
      OP_BLOCK_END: begin
        if (cfg.tracing_enable) begin
          q_cmd.crash = cfg.crash_point_enable && (block_addr == cfg.crash_point_addr);
          if (in_window && !exc_ignored) begin
            if (is_systick) begin
              if ({1'b0, mark_idx} < cfg.instrument_limit) begin
                q_cmd.kind = CMD_MARK;
                q_cmd.addr = mark_idx;
              end
            end else if ({2'b0, edge_loc} < cfg.instrument_limit) begin
              q_cmd.kind    = CMD_INC;
              q_cmd.addr    = {1'b0, edge_loc ^ hist_loc};
              hist_loc_next = {1'b0, edge_loc[LOC_W-1:1]};
              if (tick_count > cfg.hang_limit) begin
                q_cmd.hang      = 1'b1;
                tick_count_next = '0;
              end
              q_cmd.fault = irq_active && (exception_number < FAULT_EXC_LIMIT);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_loc   <= '0;
      tick_count <= '0;
    end else if (q_push) begin
      hist_loc   <= hist_loc_next;
      tick_count <= tick_count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_push_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_push)
    else $error("front pushed a command during the map clearing pass");
`endif

endmodule

// ===== design/ecbt_queue.sv =====
// Small command queue between the front end and the map back end.
module ecbt_queue import ecbt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready = count != CNT_W'(DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds its depth");
`endif

endmodule

// ===== design/ecbt_back.sv =====
// Back end: owns the coverage map memory, applies commands and drives results.
module ecbt_back import ecbt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       crash_point_hit,
  output logic       hang_detected,
  output logic       fault_detected,
  output logic [7:0] map_byte
);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOKUP
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [MAP_AW-1:0] clr_addr;
  logic [7:0]        mem [MAP_BYTES];
  logic [7:0]        mem_rdata;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign clearing = state == B_CLEAR;
  // A command is taken only when the result register will be free for it.
  assign q_pop    = (state == B_IDLE) && q_valid && (!out_valid || out_ready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.addr;
    mem_wdata = 8'd0;
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      B_LOOKUP: begin
        if (cur.kind == CMD_INC) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata + 8'd1;
        end else if (cur.kind == CMD_MARK) begin
          mem_we    = mem_rdata == 8'd0;
          mem_wdata = 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      mem_rdata <= mem[q_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cur   <= q_cmd;
            state <= B_LOOKUP;
          end
        end
        B_LOOKUP: begin
          out_valid       <= 1'b1;
          crash_point_hit <= cur.crash;
          hang_detected   <= cur.hang;
          fault_detected  <= cur.fault;
          map_byte        <= (cur.kind == CMD_READ) ? mem_rdata : 8'd0;
          state           <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == B_LOOKUP |-> !out_valid)
    else $error("result register still occupied when a new result is ready");
  a_lookup_done: assert property (@(posedge clk) disable iff (rst)
    state == B_LOOKUP |=> state == B_IDLE && out_valid)
    else $error("lookup did not complete in one cycle");
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("command taken during the clearing pass");
`endif

endmodule

// ===== design/edge_coverage_bitmap_tracker_unit.sv =====
// Top level of the edge coverage bitmap tracker: configuration registers and wiring.
//
//   channel  handshake                 payload
//   in       in_valid / in_ready       op, block_addr, irq_active, exception_number, read_index
//   out      out_valid / out_ready     crash_point_hit, hang_detected, fault_detected, map_byte
//   cfg      cfg_we                    cfg_index, cfg_data
//
// After reset the map is swept to zero, one byte a cycle; in_ready is low.
// An item then goes through the back end as a map read in B_IDLE, then the write and result
// in B_LOOKUP; the back end takes no new item until it is through with the last one.
// From acceptance an item waits in the queue before the map read; out_valid rises from B_LOOKUP.
// The queue lets items be accepted while a result waits for out_ready.
module edge_coverage_bitmap_tracker_unit import ecbt_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] block_addr,
  input  logic        irq_active,
  input  logic [8:0]  exception_number,
  input  logic [15:0] read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crash_point_hit,
  output logic        hang_detected,
  output logic        fault_detected,
  output logic [7:0]  map_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  logic clearing;
  logic q_ready;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tracing_enable     <= 1'b0;
      cfg.code_start         <= '0;
      cfg.code_end           <= '1;
      cfg.instrument_limit   <= LIMIT_W'(MAP_BYTES);
      cfg.hang_limit         <= 32'd10;
      cfg.crash_point_addr   <= '0;
      cfg.crash_point_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACING_ENABLE:     cfg.tracing_enable     <= cfg_data[0];
        REG_CODE_START:         cfg.code_start         <= cfg_data;
        REG_CODE_END:           cfg.code_end           <= cfg_data;
        REG_INSTRUMENT_LIMIT:   cfg.instrument_limit   <= cfg_data[LIMIT_W-1:0];
        REG_HANG_LIMIT:         cfg.hang_limit         <= cfg_data;
        REG_CRASH_POINT_ADDR:   cfg.crash_point_addr   <= cfg_data;
        REG_CRASH_POINT_ENABLE: cfg.crash_point_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ecbt_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .clearing         (clearing),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .block_addr       (block_addr),
    .irq_active       (irq_active),
    .exception_number (exception_number),
    .read_index       (read_index),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_cmd            (q_push_cmd)
  );

  ecbt_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  ecbt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cmd           (q_head),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crash_point_hit (crash_point_hit),
    .hang_detected   (hang_detected),
    .fault_detected  (fault_detected),
    .map_byte        (map_byte)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the edge coverage bitmap tracker top level.
module testbench;
  import ecbt_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] REG_NONE    = 3'd7;
  localparam int DRAIN_CYCLES        = 8;
  localparam int TIMEOUT_CYCLES      = 500000;
  localparam int TOUCHED_KEEP        = 64;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic        irq;
    logic [8:0]  exc;
    logic [15:0] ridx;
  } trace_txn_t;

  typedef struct {
    logic       crash;
    logic       hang;
    logic       fault;
    logic [7:0] mbyte;
  } cov_outcome_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [31:0] block_addr;
  logic        irq_active;
  logic [8:0]  exception_number;
  logic [15:0] read_index;
  logic        out_valid;
  logic        out_ready;
  logic        crash_point_hit;
  logic        hang_detected;
  logic        fault_detected;
  logic [7:0]  map_byte;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  edge_coverage_bitmap_tracker_unit dut (.*);

  // Shadow copy of the block: registers, coverage map, edge history and tick counter.
  cfg_t        cfg_shadow;
  logic [7:0]  shadow_map [MAP_BYTES];
  logic [14:0] hist_loc;
  logic [31:0] tick_cnt;
  logic [15:0] last_edge_idx;
  logic [15:0] last_mark_idx;
  logic [15:0] touched_idx [$];
  logic [31:0] addr_pool [4];

  cov_outcome_t pending_outcomes [$];
  int  mismatches = 0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;
  int  sink_hold_cycles = 0;

  always #5 clk = ~clk;

  function automatic void note_touched(logic [15:0] idx);
    touched_idx.insert(touched_idx.size(), idx);
    if (touched_idx.size() > TOUCHED_KEEP) void'(touched_idx.pop_front());
  endfunction

  function automatic cov_outcome_t predict_outcome(trace_txn_t t);
    cov_outcome_t r;
    logic [63:0]  a64;
    logic [63:0]  h;
    logic [16:0]  idx;
    logic [14:0]  c;
    logic [15:0]  e;
    r = '{crash: 1'b0, hang: 1'b0, fault: 1'b0, mbyte: 8'd0};
    case (t.op)
      OP_TICK: if (tick_cnt != 32'hFFFF_FFFF) tick_cnt = tick_cnt + 1;
      OP_READ: r.mbyte = shadow_map[t.ridx];
      OP_BLOCK_END: if (cfg_shadow.tracing_enable) begin
        if (cfg_shadow.crash_point_enable && t.addr == cfg_shadow.crash_point_addr)
          r.crash = 1'b1;
        if (t.addr >= cfg_shadow.code_start && t.addr <= cfg_shadow.code_end &&
            !(t.irq && t.exc > SYSTICK_EXC)) begin
          a64 = {32'd0, t.addr};
          h = (a64 >> 8) ^ (a64 << 4);
          if (t.irq && t.exc == SYSTICK_EXC) begin
            // Systick lands in the upper half and is only ever marked once.
            idx = {2'b01, h[14:0]};
            if (idx < cfg_shadow.instrument_limit && shadow_map[idx[15:0]] == 8'd0) begin
              shadow_map[idx[15:0]] = 8'd1;
              last_mark_idx = idx[15:0];
              note_touched(idx[15:0]);
            end
          end else begin
            c = h[14:0];
            if ({2'b00, c} < cfg_shadow.instrument_limit) begin
              e = {1'b0, c ^ hist_loc};
              shadow_map[e] = shadow_map[e] + 8'd1;
              last_edge_idx = e;
              note_touched(e);
              hist_loc = c >> 1;
              if (tick_cnt > cfg_shadow.hang_limit) begin
                tick_cnt = 32'd0;
                r.hang = 1'b1;
              end
              if (t.irq && t.exc < FAULT_EXC_LIMIT) r.fault = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic trace_txn_t make_item(logic [1:0] o, logic [31:0] a, logic i,
                                           logic [8:0] x, logic [15:0] r);
    trace_txn_t t;
    t.op = o;
    t.addr = a;
    t.irq = i;
    t.exc = x;
    t.ridx = r;
    return t;
  endfunction

  function automatic trace_txn_t random_item();
    trace_txn_t t;
    int pick;
    t.op = OP_BLOCK_END;
    t.addr = addr_pool[$urandom_range(3)];
    t.irq = 1'b0;
    t.exc = 9'($urandom_range(511));
    t.ridx = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      t.op = OP_TICK;
    end else if (pick < 35) begin
      t.op = OP_READ;
      if (touched_idx.size() > 0 && $urandom_range(3) != 0)
        t.ridx = touched_idx[$urandom_range(touched_idx.size() - 1)];
    end else if (pick < 39) begin
      t.op = OP_UNUSED;
    end
    pick = $urandom_range(99);
    if (pick < 20) begin
      t.addr = $urandom;
    end else if (pick < 30) begin
      case ($urandom_range(4))
        0: t.addr = cfg_shadow.code_start;
        1: t.addr = cfg_shadow.code_start - 32'd1;
        2: t.addr = cfg_shadow.code_end;
        3: t.addr = cfg_shadow.code_end + 32'd1;
        default: t.addr = cfg_shadow.crash_point_addr;
      endcase
    end
    if ($urandom_range(99) < 30) begin
      t.irq = 1'b1;
      case ($urandom_range(3))
        0: t.exc = SYSTICK_EXC;
        1: t.exc = 9'($urandom_range(9));
        2: t.exc = 9'($urandom_range(10, 14));
        default: ;
      endcase
    end
    return t;
  endfunction

  // Addresses inside the current code window, so that most edges get recorded.
  task automatic refill_pool();
    logic [63:0] span;
    span = {32'd0, cfg_shadow.code_end} - {32'd0, cfg_shadow.code_start};
    for (int k = 0; k < 4; k++) begin
      if (cfg_shadow.code_end < cfg_shadow.code_start)
        addr_pool[k] = $urandom;
      else
        addr_pool[k] = cfg_shadow.code_start + 32'({$urandom, $urandom} % (span + 64'd1));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TRACING_ENABLE:     cfg_shadow.tracing_enable = val[0];
      REG_CODE_START:         cfg_shadow.code_start = val;
      REG_CODE_END:           cfg_shadow.code_end = val;
      REG_INSTRUMENT_LIMIT:   cfg_shadow.instrument_limit = val[LIMIT_W-1:0];
      REG_HANG_LIMIT:         cfg_shadow.hang_limit = val;
      REG_CRASH_POINT_ADDR:   cfg_shadow.crash_point_addr = val;
      REG_CRASH_POINT_ENABLE: cfg_shadow.crash_point_enable = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input trace_txn_t t);
    int gap;
    gap = 0;
    if (!src_steady && $urandom_range(99) < 10) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= t.op;
    block_addr <= t.addr;
    irq_active <= t.irq;
    exception_number <= t.exc;
    read_index <= t.ridx;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.insert(pending_outcomes.size(), predict_outcome(t));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Stops offering items and waits until every outstanding result has been checked.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_tracing_off();
    send_item(make_item(OP_BLOCK_END, 32'h0000_0000, 1'b0, 9'd0, 16'd0));
    send_item(make_item(OP_READ, 32'hFFFF_FFFF, 1'b1, 9'd511, 16'hFFFF));
    send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 9'd511, 16'hFFFF));
    send_item(make_item(OP_TICK, 32'h0, 1'b0, 9'd0, 16'd0));
    settle();
  endtask

  task automatic test_directed_cases();
    write_reg(REG_TRACING_ENABLE, 32'd1);
    write_reg(REG_HANG_LIMIT, 32'd3);
    write_reg(REG_CRASH_POINT_ADDR, 32'h0000_1234);
    write_reg(REG_CRASH_POINT_ENABLE, 32'd1);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_item(make_item(OP_BLOCK_END, 32'h0000_0000, 1'b0, 9'd0, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'hFFFF_FFFF, 1'b0, 9'd0, 16'd0));
    repeat (4) send_item(make_item(OP_TICK, 32'h0, 1'b0, 9'd0, 16'd0));
    // Crash point together with a hang, since the tick count is now above the limit.
    send_item(make_item(OP_BLOCK_END, 32'h0000_1234, 1'b0, 9'd0, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_ABCD, 1'b1, 9'd0, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_ABCD, 1'b1, 9'd9, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_ABCD, 1'b1, 9'd10, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_1234, 1'b1, 9'd16, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_5678, 1'b1, 9'd511, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_5678, 1'b1, SYSTICK_EXC, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_5678, 1'b1, SYSTICK_EXC, 16'd0));
    send_item(make_item(OP_READ, 32'h0, 1'b0, 9'd0, last_mark_idx));
    send_item(make_item(OP_READ, 32'h0, 1'b0, 9'd0, last_edge_idx));
    send_item(make_item(OP_READ, 32'h0, 1'b0, 9'd0, 16'h0000));
    send_item(make_item(OP_UNUSED, 32'h0000_1234, 1'b1, 9'd0, 16'hFFFF));
    settle();
    write_reg(REG_CODE_START, 32'h0000_1000);
    write_reg(REG_CODE_END, 32'h0000_1FFF);
    write_reg(REG_CRASH_POINT_ADDR, 32'h0000_2000);
    write_reg(REG_INSTRUMENT_LIMIT, 32'h0000_8000);
    send_item(make_item(OP_BLOCK_END, 32'h0000_0FFF, 1'b0, 9'd0, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_1000, 1'b0, 9'd0, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_1FFF, 1'b1, SYSTICK_EXC, 16'd0));
    send_item(make_item(OP_BLOCK_END, 32'h0000_2000, 1'b1, 9'd3, 16'd0));
    settle();
    write_reg(REG_INSTRUMENT_LIMIT, 32'd0);
    send_item(make_item(OP_BLOCK_END, 32'h0000_1800, 1'b1, 9'd2, 16'd0));
    send_item(make_item(OP_READ, 32'h0, 1'b0, 9'd0, last_edge_idx));
    settle();
  endtask

  // One hot edge hit hundreds of times, so its counter wraps past 255.
  task automatic test_counter_wrap();
    trace_txn_t t;
    write_reg(REG_CODE_START, 32'd0);
    write_reg(REG_CODE_END, 32'hFFFF_FFFF);
    write_reg(REG_INSTRUMENT_LIMIT, 32'd65536);
    write_reg(REG_HANG_LIMIT, 32'd20);
    addr_pool[0] = $urandom;
    for (int k = 1; k < 4; k++) addr_pool[k] = addr_pool[0];
    repeat (300) begin
      t = random_item();
      if ($urandom_range(9) != 0) begin
        t.op = OP_BLOCK_END;
        t.irq = 1'b0;
        t.addr = addr_pool[0];
      end
      send_item(t);
    end
    settle();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_CRASH_POINT_ADDR, $urandom);
    write_reg(REG_HANG_LIMIT, 32'd5);
    refill_pool();
    write_reg(REG_CRASH_POINT_ADDR, addr_pool[1]);
    send_random(70);
    settle();

    write_reg(REG_CODE_START, 32'hFFFF_FFFF);
    write_reg(REG_CODE_END, 32'hFFFF_FFFF);
    write_reg(REG_INSTRUMENT_LIMIT, 32'h0001_FFFF);
    write_reg(REG_HANG_LIMIT, 32'd0);
    write_reg(REG_CRASH_POINT_ADDR, 32'hFFFF_FFFF);
    refill_pool();
    send_random(70);
    settle();

    write_reg(REG_CODE_START, $urandom);
    write_reg(REG_CODE_END, cfg_shadow.code_start + 32'($urandom_range(1 << 20)));
    write_reg(REG_INSTRUMENT_LIMIT, 32'h0000_4000);
    write_reg(REG_HANG_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_CRASH_POINT_ENABLE, 32'd0);
    refill_pool();
    send_random(70);
    settle();

    write_reg(REG_TRACING_ENABLE, 32'd0);
    send_random(30);
    settle();

    write_reg(REG_TRACING_ENABLE, 32'd1);
    write_reg(REG_CODE_START, 32'd0);
    write_reg(REG_CODE_END, 32'd0);
    write_reg(REG_INSTRUMENT_LIMIT, 32'd65536);
    write_reg(REG_HANG_LIMIT, 32'd2);
    write_reg(REG_CRASH_POINT_ADDR, 32'd0);
    write_reg(REG_CRASH_POINT_ENABLE, 32'd1);
    refill_pool();
    send_random(70);
    settle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_CODE_END, 32'hFFFF_FFFF);
    write_reg(REG_HANG_LIMIT, 32'd6);
    refill_pool();
    // The receiver holds off while the sender keeps offering, filling the queue.
    sink_hold_cycles = 300;
    send_random(60);
    settle();
  endtask

  task automatic test_sender_pause();
    send_random(40);
    settle();
    send_random(40);
    settle();
  endtask

  task automatic test_steady_stream();
    src_steady = 1'b1;
    sink_steady = 1'b1;
    send_random(80);
    settle();
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cov_outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display({"%0t: unexpected result: expected none, ",
                  "actual crash %0b hang %0b fault %0b byte %0h"},
                 $time, crash_point_hit, hang_detected, fault_detected, map_byte);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("crash_point_hit", {7'd0, want.crash}, {7'd0, crash_point_hit});
        check_field("hang_detected", {7'd0, want.hang}, {7'd0, hang_detected});
        check_field("fault_detected", {7'd0, want.fault}, {7'd0, fault_detected});
        check_field("map_byte", want.mbyte, map_byte);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles--;
      end else if (sink_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_BLOCK_END;
    block_addr = 32'd0;
    irq_active = 1'b0;
    exception_number = 9'd0;
    read_index = 16'd0;
    cfg_we = 1'b0;
    cfg_index = REG_TRACING_ENABLE;
    cfg_data = 32'd0;
    cfg_shadow.tracing_enable = 1'b0;
    cfg_shadow.code_start = 32'd0;
    cfg_shadow.code_end = 32'hFFFF_FFFF;
    cfg_shadow.instrument_limit = LIMIT_W'(MAP_BYTES);
    cfg_shadow.hang_limit = 32'd10;
    cfg_shadow.crash_point_addr = 32'd0;
    cfg_shadow.crash_point_enable = 1'b0;
    for (int k = 0; k < MAP_BYTES; k++) shadow_map[k] = 8'd0;
    hist_loc = '0;
    tick_cnt = 32'd0;
    last_edge_idx = 16'd0;
    last_mark_idx = 16'd0;
    for (int k = 0; k < 4; k++) addr_pool[k] = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The map is swept clear after reset; wait until the block takes items.
    do @(posedge clk); while (!in_ready);

    test_tracing_off();
    test_directed_cases();
    test_counter_wrap();
    test_config_sweep();
    test_backpressure();
    test_sender_pause();
    test_steady_stream();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ecbt_pkg.sv
design/ecbt_front.sv
design/ecbt_queue.sv
design/ecbt_back.sv
design/edge_coverage_bitmap_tracker_unit.sv
sim/testbench.sv
